// ===== rtl/core/sspq_pkg.sv =====
// shared types and constants for the sorted priority queue
`default_nettype none

package sspq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int ACT_BITS     = 2;

    // request codes; the fourth code behaves as a query
    typedef enum logic [ACT_BITS-1:0] {
        ACT_QUERY  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sspq_req_if.sv =====
// request channel: action, key and tag
`default_nettype none

interface sspq_req_if #(
    parameter int KEY_BITS = sspq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sspq_pkg::TAG_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [sspq_pkg::ACT_BITS-1:0] action;
    logic [KEY_BITS-1:0]           key;
    logic [TAG_BITS-1:0]           tag;

    modport source (output valid, action, key, tag, input ready);
    modport sink   (input valid, action, key, tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sspq_rsp_if.sv =====
// result channel: front entry and queue status
`default_nettype none

interface sspq_rsp_if #(
    parameter int KEY_BITS = sspq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sspq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS = $clog2(sspq_pkg::DEPTH_DEF + 1)
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] front_key;
    logic [TAG_BITS-1:0] front_tag;
    logic                is_empty;
    logic                is_full;
    logic [CNT_BITS-1:0] occupancy;
    logic                dropped;

    modport source (output valid, front_key, front_tag, is_empty, is_full, occupancy,
                    dropped, input ready);
    modport sink   (input valid, front_key, front_tag, is_empty, is_full, occupancy,
                    dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sspq_cell.sv =====
// one slot of the sorted store with its neighbour shift logic
`default_nettype none

module sspq_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = sspq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sspq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS = 5
) (
    input  wire                  clk,
    input  wire sspq_pkg::cmd_t  cmd,
    input  wire [CNT_BITS-1:0]   count,
    input  wire [KEY_BITS-1:0]   new_key,
    input  wire [TAG_BITS-1:0]   new_tag,
    input  wire                  left_le,
    input  wire [KEY_BITS-1:0]   left_key,
    input  wire [TAG_BITS-1:0]   left_tag,
    input  wire [KEY_BITS-1:0]   right_key,
    input  wire [TAG_BITS-1:0]   right_tag,
    output logic                 le,
    output logic [KEY_BITS-1:0]  key,
    output logic [TAG_BITS-1:0]  tag
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                occupied;

    assign occupied = count > CNT_BITS'(INDEX);
    // held entry stays in front of the new one
    assign le       = occupied && (key_reg <= new_key);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.ins)
        begin
            if (!le)
            begin
                if (left_le)
                begin
                    key_next = new_key;
                    tag_next = new_tag;
                end
                else
                begin
                    key_next = left_key;
                    tag_next = left_tag;
                end
            end
        end
        else if (cmd.rem)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stable_sorted_priority_queue_top.sv =====
// top level of the stable sorted priority queue: cell chain, count and result register
//
//  channel | dir | fields                                                        
//  req     | in  | action, key, tag                                              
//  rsp     | out | front_key, front_tag, is_empty, is_full, occupancy, dropped   
//
// one item per cycle while the result slot is free or drains: every cell compares its key
// with the new key at once, so insert and remove each update the whole cell chain together.
// the result of an item is presented the cycle after it is taken and held
// until the sink takes it; a new item is taken in that same cycle.
// reset clears the entry count and the result slot; stored entries are not
// cleared, only slots below the count are ever shown.
`default_nettype none

module stable_sorted_priority_queue_top #(
    parameter int DEPTH    = sspq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = sspq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sspq_pkg::TAG_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    sspq_req_if.sink   req,
    sspq_rsp_if.source rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                out_valid_reg;
    logic                dropped_reg, dropped_next;
    logic                accept;
    logic                is_ins, is_rem, full, empty;
    sspq_pkg::cmd_t      cmd;

    // chain wiring, one entry per cell
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic                cell_le  [DEPTH];

    // state only moves on an accepted item, and an item is taken only when
    // the result slot is free or drains this cycle, so the shown result
    // can be read straight from the cells and the count
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full  = count_reg == CNT_BITS'(DEPTH);
    assign empty = count_reg == '0;

    always_comb
    begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        case (req.action)
            sspq_pkg::ACT_INSERT: is_ins = 1'b1;
            sspq_pkg::ACT_REMOVE: is_rem = 1'b1;
            default:              ;
        endcase
    end

    assign cmd.ins = accept && is_ins && !full;
    assign cmd.rem = accept && is_rem && !empty;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.ins)
            count_next = count_reg + CNT_BITS'(1);
        else if (cmd.rem)
            count_next = count_reg - CNT_BITS'(1);
        if (accept)
            dropped_next = is_ins && full;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            // head cell always sees a smaller neighbour; tail cell refills from itself
            localparam int LI = (gi == 0) ? 0 : gi - 1;
            localparam int RI = (gi == DEPTH - 1) ? gi : gi + 1;

            sspq_cell #(
                .INDEX    (gi),
                .KEY_BITS (KEY_BITS),
                .TAG_BITS (TAG_BITS),
                .CNT_BITS (CNT_BITS)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .new_key   (req.key),
                .new_tag   (req.tag),
                .left_le   ((gi == 0) ? 1'b1 : cell_le[LI]),
                .left_key  (cell_key[LI]),
                .left_tag  (cell_tag[LI]),
                .right_key (cell_key[RI]),
                .right_tag (cell_tag[RI]),
                .le        (cell_le[gi]),
                .key       (cell_key[gi]),
                .tag       (cell_tag[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // front entry reads as zero when the queue is empty
    assign rsp.valid     = out_valid_reg;
    assign rsp.front_key = empty ? '0 : cell_key[0];
    assign rsp.front_tag = empty ? '0 : cell_tag[0];
    assign rsp.is_empty  = empty;
    assign rsp.is_full   = full;
    assign rsp.occupancy = count_reg;
    assign rsp.dropped   = dropped_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above capacity");

    // a refused insert is only ever flagged against a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> full)
        else $error("drop flagged while not full");

    // an accepted insert into a queue with room grows it by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_ins && !full) |=> (count_reg == $past(count_reg) + CNT_BITS'(1)))
        else $error("insert did not add an entry");

    // a remove on an empty queue leaves it empty
    a_rem_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_rem && empty) |=> empty)
        else $error("remove from empty queue changed the count");

endmodule

`default_nettype wire
